### sv/b85_pkg.sv
// ---------------------------------------------------------------------------
// b85_pkg - shared types and constants for the base-85 stream encoder
// Group entry type, radix constants and the fixed-point reciprocal of 85.
// ---------------------------------------------------------------------------
package b85_pkg;

	localparam int          GROUP_BYTES   = 4;
	localparam int          QUEUE_DEPTH   = 2;
	localparam logic [6:0]  SYM_BASE      = 7'd37;
	localparam logic [13:0] RADIX         = 14'd85;
	// floor(n / 85) == (n * RECIP) >> RECIP_SHIFT for every 32-bit n
	localparam logic [63:0] RECIP         = 64'h0000_0000_C0C0_C0C1;
	localparam int          RECIP_SHIFT   = 38;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nsym;   // symbols to emit, 2..5
		logic        last;
	} group_t;

endpackage

### sv/b85_if.sv
// ---------------------------------------------------------------------------
// b85 channel interfaces
// Byte input channel and symbol output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface b85_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b85_sym_if;
	logic       valid;
	logic       ready;
	logic [6:0] symbol;
	logic       group_end;
	logic       stream_end;

	modport source (output valid, output symbol, output group_end, output stream_end,
		input ready);
	modport sink   (input valid, input symbol, input group_end, input stream_end,
		output ready);
endinterface

### sv/b85_front.sv
// ---------------------------------------------------------------------------
// b85_front - byte packer
// Packs bytes little-endian into a 32-bit word and hands a group to the
// queue when four bytes are in or the byte is marked last.
// ---------------------------------------------------------------------------
module b85_front (
	input  logic            clk,
	input  logic            arst_n,
	b85_byte_if.sink        byte_chan,
	input  logic            push_ready,
	output logic            push_valid,
	output b85_pkg::group_t push_entry
);

	logic [31:0] acc_q;
	logic [1:0]  pos_q;
	logic [31:0] acc_new;
	logic        accept;
	logic        flush;

	assign byte_chan.ready = push_ready;
	assign accept  = byte_chan.valid && byte_chan.ready;
	assign acc_new = acc_q | (32'(byte_chan.data_byte) << {pos_q, 3'b000});
	assign flush   = byte_chan.last_byte
		|| (pos_q == 2'(b85_pkg::GROUP_BYTES - 1));

	assign push_valid      = accept && flush;
	assign push_entry.word = acc_new;
	assign push_entry.nsym = {1'b0, pos_q} + 3'd2;
	assign push_entry.last = byte_chan.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			if (flush) begin
				acc_q <= '0;
				pos_q <= '0;
			end else begin
				acc_q <= acc_new;
				pos_q <= pos_q + 2'd1;
			end
		end
	end

endmodule

### sv/b85_queue.sv
// ---------------------------------------------------------------------------
// b85_queue - group queue
// Small register FIFO between the packer and the digit unit.
// ---------------------------------------------------------------------------
module b85_queue #(
	parameter int DEPTH = b85_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  b85_pkg::group_t push_entry,
	output logic            push_ready,
	output logic            pop_valid,
	output b85_pkg::group_t pop_entry,
	input  logic            pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b85_pkg::group_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/b85_back.sv
// ---------------------------------------------------------------------------
// b85_back - digit unit
// Peels one base-85 digit per cycle off the group word (low digit first)
// while the symbol output is not stalled, and drives the symbol output register.
// ---------------------------------------------------------------------------
module b85_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	input  b85_pkg::group_t pop_entry,
	output logic            pop,
	b85_sym_if.source       sym_chan
);

	logic        busy_q;
	logic [31:0] word_q;
	logic [2:0]  rem_q;
	logic        last_q;

	logic        out_valid_q;
	logic [6:0]  symbol_q;
	logic        group_end_q;
	logic        stream_end_q;

	logic [63:0] prod;
	logic [25:0] quot;
	logic [13:0] q85;
	logic [6:0]  digit;
	logic        adv;
	logic        final_sym;

	// quotient by 85 through the reciprocal; digit needs only the low 7 bits
	assign prod  = {32'd0, word_q} * b85_pkg::RECIP;
	assign quot  = prod[63:b85_pkg::RECIP_SHIFT];
	assign q85   = 14'(quot[6:0]) * b85_pkg::RADIX;
	assign digit = word_q[6:0] - q85[6:0];

	assign adv       = busy_q && (!out_valid_q || sym_chan.ready);
	assign final_sym = (rem_q == 3'd1);
	assign pop       = pop_valid && (!busy_q || (adv && final_sym));

	assign sym_chan.valid      = out_valid_q;
	assign sym_chan.symbol     = symbol_q;
	assign sym_chan.group_end  = group_end_q;
	assign sym_chan.stream_end = stream_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				rem_q  <= pop_entry.nsym;
			end else if (adv) begin
				rem_q <= rem_q - 3'd1;
				if (final_sym) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (sym_chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= pop_entry.word;
			last_q <= pop_entry.last;
		end else if (adv) begin
			word_q <= {6'd0, quot};
		end
		if (adv) begin
			symbol_q     <= digit + b85_pkg::SYM_BASE;
			group_end_q  <= final_sym;
			stream_end_q <= final_sym && last_q;
		end
	end

endmodule

### sv/base85_stream_encoder_unit.sv
// Path: the group closed by a byte is written into the queue, then loaded
// into the digit unit's word register; each digit is then registered into
// the symbol output register. Throughput: the digit unit emits one symbol
// per cycle while the output is not stalled; 4 bytes give 5 symbols.
// Reset: arst_n clears the accumulator, byte position, queue and output
// valid at once; the block is ready as soon as reset is released.
// ---------------------------------------------------------------------------
// base85_stream_encoder_unit - streaming base-85 encoder
// Packer front end, group queue and digit unit back end.
// ---------------------------------------------------------------------------
module base85_stream_encoder_unit #(
	parameter int QUEUE_DEPTH = b85_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	b85_byte_if.sink  byte_chan,
	b85_sym_if.source sym_chan
);

	logic            push_valid;
	logic            push_ready;
	b85_pkg::group_t push_entry;
	logic            pop_valid;
	logic            pop;
	b85_pkg::group_t pop_entry;

	b85_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_chan  (byte_chan),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	b85_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop        (pop)
	);

	b85_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop       (pop),
		.sym_chan  (sym_chan)
	);

endmodule

### sv/b85_checker.sv
// ---------------------------------------------------------------------------
// b85_checker - port-level checks
// Watches the symbol channel for group framing and character range.
// ---------------------------------------------------------------------------
module b85_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] symbol,
	input logic       group_end,
	input logic       stream_end
);

	logic [2:0] sym_cnt_q;
	logic       out_fire;

	assign out_fire = out_valid && out_ready;

	// symbols seen so far in the current group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_cnt_q <= '0;
		end else if (out_fire) begin
			sym_cnt_q <= group_end ? 3'd0 : sym_cnt_q + 3'd1;
		end
	end

	a_stream_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> group_end)
		else $error("stream_end without group_end");

	a_group_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && (sym_cnt_q == 3'd0) |-> !group_end)
		else $error("group closed after one symbol");

	a_group_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && (sym_cnt_q == 3'd4) |-> group_end)
		else $error("group longer than five symbols");

	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (symbol >= 7'd37) && (symbol <= 7'd121))
		else $error("symbol out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid && !out_ready) |-> out_valid && $stable(symbol)
			&& $stable(group_end) && $stable(stream_end))
		else $error("stalled word changed");

endmodule

bind base85_stream_encoder_unit b85_checker u_b85_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (sym_chan.valid),
	.out_ready  (sym_chan.ready),
	.symbol     (sym_chan.symbol),
	.group_end  (sym_chan.group_end),
	.stream_end (sym_chan.stream_end)
);
